// ===== rtl/mnp_pkg.sv =====
// ----------------------------------------------------------------------------
// mnp_pkg
// Shared constants, types and helpers of the 2x2 mask to nibble packer.
// ----------------------------------------------------------------------------
package mnp_pkg;

  // Default size limits, handed to the top level parameters
  localparam int MAX_SRC_WIDTH_DEF   = 2048;
  localparam int MAX_SRC_HEIGHT_DEF  = 2048;
  localparam int MAX_DEST_WIDTH_DEF  = 1024;
  localparam int MAX_DEST_HEIGHT_DEF = 1024;

  // Working width of the geometry math; covers the default parameter values
  localparam int CW = 16;

  // Field widths
  localparam int ADDR_W     = 19;
  localparam int NIB_W      = 4;
  localparam int DEST_DIM_W = 11;
  localparam int SRC_DIM_W  = 12;
  localparam int OFF_W      = 11;
  localparam int LANES      = 4;
  localparam int OUT_DATA_W = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd5;

  // Register reset values
  localparam logic [DEST_DIM_W-1:0] DEST_WIDTH_RST  = 11'd640;
  localparam logic [DEST_DIM_W-1:0] DEST_HEIGHT_RST = 11'd480;
  localparam logic [SRC_DIM_W-1:0]  SRC_WIDTH_RST   = 12'd1280;
  localparam logic [SRC_DIM_W-1:0]  SRC_HEIGHT_RST  = 12'd960;

  // Clipped placement of the mask on the destination
  typedef struct packed {
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] srcx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] srcy;
    logic signed [CW-1:0] width;
    logic signed [CW-1:0] height;
    logic        [CW-1:0] dpitch;
  } geo_t;

  // Up to four nibble writes caused by one source byte
  typedef struct packed {
    logic [LANES-1:0]             mask;
    logic [LANES-1:0][ADDR_W-1:0] addr;
    logic [LANES-1:0][NIB_W-1:0]  nib;
    logic [LANES-1:0]             upper;
  } grp_t;

  // Saturate an unsigned value to a limit
  function automatic logic [CW-1:0] clamp_u(logic [CW-1:0] v, logic [CW-1:0] hi);
    return (v > hi) ? hi : v;
  endfunction

endpackage

// ===== rtl/mnp_line_store.sv =====
// ----------------------------------------------------------------------------
// mnp_line_store
// Single-port-write, registered-read memory holding the top row of a pair.
// ----------------------------------------------------------------------------
module mnp_line_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Write the top-row byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data follows in the cycle after the request
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/mnp_geometry.sv =====
// ----------------------------------------------------------------------------
// mnp_geometry
// Registers the clipped placement derived from the size and offset registers.
// ----------------------------------------------------------------------------
module mnp_geometry #(
  parameter int MAX_SRC_WIDTH   = mnp_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT  = mnp_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int MAX_DEST_WIDTH  = mnp_pkg::MAX_DEST_WIDTH_DEF,
  parameter int MAX_DEST_HEIGHT = mnp_pkg::MAX_DEST_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic [mnp_pkg::DEST_DIM_W-1:0]   dest_width,
  input  logic [mnp_pkg::DEST_DIM_W-1:0]   dest_height,
  input  logic [mnp_pkg::SRC_DIM_W-1:0]    src_width,
  input  logic [mnp_pkg::SRC_DIM_W-1:0]    src_height,
  input  logic [mnp_pkg::OFF_W-1:0]        x_offset,
  input  logic [mnp_pkg::OFF_W-1:0]        y_offset,
  output mnp_pkg::geo_t                    geo
);

  localparam int CW = mnp_pkg::CW;

  logic        [CW-1:0] sw, sh, dw, dh;
  logic signed [CW-1:0] x_s, y_s, w0, h0, w1, h1, dx, dy, srcx, srcy;
  logic signed [CW-1:0] dw_s, dh_s;
  mnp_pkg::geo_t        geo_nxt;

  // Saturate sizes, shift off negative offsets, then clip to the destination
  always_comb begin
    sw   = mnp_pkg::clamp_u(CW'(src_width),   CW'(MAX_SRC_WIDTH));
    sh   = mnp_pkg::clamp_u(CW'(src_height),  CW'(MAX_SRC_HEIGHT));
    dw   = mnp_pkg::clamp_u(CW'(dest_width),  CW'(MAX_DEST_WIDTH));
    dh   = mnp_pkg::clamp_u(CW'(dest_height), CW'(MAX_DEST_HEIGHT));
    dw_s = $signed(dw);
    dh_s = $signed(dh);
    x_s  = CW'($signed(x_offset));
    y_s  = CW'($signed(y_offset));
    w0   = $signed(sw >> 1);
    h0   = $signed(sh >> 1);

    if (x_s < 0) begin
      srcx = -(x_s <<< 1);
      w1   = w0 + x_s;
      dx   = '0;
    end else begin
      srcx = '0;
      w1   = w0;
      dx   = x_s;
    end

    if (y_s < 0) begin
      srcy = -y_s;
      h1   = h0 + y_s;
      dy   = '0;
    end else begin
      srcy = '0;
      h1   = h0;
      dy   = y_s;
    end

    geo_nxt.dx     = dx;
    geo_nxt.srcx   = srcx;
    geo_nxt.dy     = dy;
    geo_nxt.srcy   = srcy;
    geo_nxt.width  = (dx + w1 > dw_s) ? dw_s - dx : w1;
    geo_nxt.height = (dy + h1 > dh_s) ? dh_s - dy : h1;
    geo_nxt.dpitch = ((dw + CW'(7)) >> 3) << 2;
  end

  // Follow the registers every cycle
  always_ff @(posedge clk) begin
    geo <= geo_nxt;
  end

endmodule

// ===== rtl/mnp_calc.sv =====
// ----------------------------------------------------------------------------
// mnp_calc
// Combines a bottom-row byte with its stored top byte into up to four
// nibble writes: row address and columns, then clip and byte addresses.
// ----------------------------------------------------------------------------
module mnp_calc #(
  parameter int BC_W  = 8,
  parameter int ROW_W = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  output logic                 s2_free,
  input  logic [7:0]           s1_mb,
  input  logic [7:0]           s1_top,
  input  logic [BC_W-1:0]      s1_bc,
  input  logic [ROW_W-1:0]     s1_srow,
  input  mnp_pkg::geo_t        geo,
  input  logic                 grp_free,
  output logic                 grp_load,
  output mnp_pkg::grp_t        grp_data
);

  localparam int CW     = mnp_pkg::CW;
  localparam int LANES  = mnp_pkg::LANES;
  localparam int ADDR_W = mnp_pkg::ADDR_W;
  localparam int NIB_W  = mnp_pkg::NIB_W;

  logic                                s2_valid_r;
  logic                                s2_ok_r;
  logic [ADDR_W-1:0]                   s2_base_r;
  logic [LANES-1:0]                    s2_start_r;
  logic [LANES-1:0][CW-1:0]            s2_col_r;
  logic [LANES-1:0][NIB_W-1:0]         s2_nib_r;

  logic signed [CW-1:0]                row, drow;
  logic                                ok;
  logic [2*CW-1:0]                     prod;
  logic [LANES-1:0]                    start;
  logic [LANES-1:0][CW-1:0]            col;
  logic [LANES-1:0][NIB_W-1:0]         nib;
  logic signed [CW-1:0]                sx, diff;
  logic signed [CW-1:0]                dcol;

  // Stage B: row check, row base address, column of each 2x2 block
  always_comb begin
    row  = $signed(CW'(s1_srow >> 1)) - geo.srcy;
    drow = geo.dy + row;
    ok   = s1_srow[0] && (geo.width > 0) && (geo.height > 0) &&
           (row >= 0) && (row < geo.height);
    prod = (2*CW)'($unsigned(drow)) * (2*CW)'(geo.dpitch);
    sx   = '0;
    diff = '0;
    for (int k = 0; k < LANES; k++) begin
      sx       = $signed(CW'({s1_bc, 3'(2 * k)}));
      diff     = sx - geo.srcx;
      start[k] = (sx >= geo.srcx);
      col[k]   = $unsigned(diff >>> 1);
      nib[k]   = {s1_top[7 - 2*k], s1_top[6 - 2*k], s1_mb[7 - 2*k], s1_mb[6 - 2*k]};
    end
  end

  assign s2_free = !s2_valid_r || grp_free;

  // Hold stage B results until the group buffer takes them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_ok_r    <= ok;
      s2_base_r  <= prod[ADDR_W-1:0];
      s2_start_r <= start;
      s2_col_r   <= col;
      s2_nib_r   <= nib;
    end
  end

  // Stage C: clip each column and form byte address and half
  always_comb begin
    dcol = '0;
    for (int k = 0; k < LANES; k++) begin
      dcol                = geo.dx + $signed(s2_col_r[k]);
      grp_data.mask[k]    = s2_ok_r && s2_start_r[k] && ($signed(s2_col_r[k]) < geo.width);
      grp_data.addr[k]    = s2_base_r + ADDR_W'($unsigned(dcol) >> 1);
      grp_data.nib[k]     = s2_nib_r[k];
      grp_data.upper[k]   = !dcol[0];
    end
  end

  assign grp_load = s2_valid_r && grp_free;

endmodule

// ===== rtl/mnp_emitter.sv =====
// ----------------------------------------------------------------------------
// mnp_emitter
// Holds one byte's group of nibble writes and sends them one per cycle while
// out_tready allows, lowest column first, through a registered output stage.
// ----------------------------------------------------------------------------
module mnp_emitter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               grp_load,
  input  mnp_pkg::grp_t                      grp_data,
  output logic                               grp_free,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mnp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast
);

  localparam int LANES  = mnp_pkg::LANES;
  localparam int ADDR_W = mnp_pkg::ADDR_W;
  localparam int NIB_W  = mnp_pkg::NIB_W;

  mnp_pkg::grp_t              grp_r;
  logic [LANES-1:0]           mask_nxt;
  logic [LANES-1:0]           rest;
  logic [1:0]                 sel;
  logic                       o_ready;
  logic                       grp_move;
  logic                       out_valid_r;
  logic [ADDR_W-1:0]          out_addr_r;
  logic [NIB_W-1:0]           out_nib_r;
  logic                       out_upper_r;
  logic                       out_last_r;

  // Pick the lowest pending lane
  always_comb begin
    sel = 2'd0;
    for (int k = LANES - 1; k >= 0; k--) begin
      if (grp_r.mask[k]) begin
        sel = 2'(k);
      end
    end
    rest = grp_r.mask & ~(LANES'(1) << sel);
  end

  assign o_ready  = !out_valid_r || out_tready;
  assign grp_move = (grp_r.mask != '0) && o_ready;
  assign grp_free = (grp_r.mask == '0) || (grp_move && (rest == '0));

  // Load a new group or drop the lane just sent
  always_comb begin
    mask_nxt = grp_r.mask;
    if (grp_load) begin
      mask_nxt = grp_data.mask;
    end else if (grp_move) begin
      mask_nxt = rest;
    end
  end

  // Hold the group; reset clears only the pending lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r.mask <= '0;
    end else begin
      grp_r.mask <= mask_nxt;
    end
    if (grp_load) begin
      grp_r.addr  <= grp_data.addr;
      grp_r.nib   <= grp_data.nib;
      grp_r.upper <= grp_data.upper;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_ready) begin
      out_valid_r <= grp_move;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_move) begin
      out_addr_r  <= grp_r.addr[sel];
      out_nib_r   <= grp_r.nib[sel];
      out_upper_r <= grp_r.upper[sel];
      out_last_r  <= (rest == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_upper_r, out_nib_r, out_addr_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/mask_2x2_to_nibble_packer.sv =====
// ----------------------------------------------------------------------------
// mask_2x2_to_nibble_packer
// Packs a double-resolution one-bit mask into nibble writes of a 4-bit
// destination, one 2x2 block per nibble, clipped and offset.
// ----------------------------------------------------------------------------
// Send the mask bytes in raster order, rows padded to whole bytes, bit 7
// leftmost. Bytes of the top row of each pair go into a line store; each
// byte of the bottom row yields zero to four nibble writes (byte address,
// nibble, half select) with tlast on the last write of that byte. A byte is
// taken every cycle while no writes are pending; a byte that yields writes
// holds the stream while the single output register drains its group, one
// write per cycle while out_tready is high. The first write passes through
// stage A, stage B, the group register and the output register. Change the
// registers only while the block is idle.
// ----------------------------------------------------------------------------
module mask_2x2_to_nibble_packer #(
  parameter int MAX_SRC_WIDTH   = mnp_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT  = mnp_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int MAX_DEST_WIDTH  = mnp_pkg::MAX_DEST_WIDTH_DEF,
  parameter int MAX_DEST_HEIGHT = mnp_pkg::MAX_DEST_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Mask byte stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,    // [7:0] mask_byte
  // Nibble write stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mnp_pkg::OUT_DATA_W-1:0]      out_tdata,   // [18:0] dest_address,
                                                           // [22:19] nibble,
                                                           // [23] upper_half
  output logic                                out_tlast,   // run_last
  // Register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mnp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mnp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW          = mnp_pkg::CW;
  localparam int STORE_DEPTH = (MAX_SRC_WIDTH + 7) / 8;
  localparam int BC_W        = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(MAX_SRC_HEIGHT);

  // Configuration registers
  logic [mnp_pkg::DEST_DIM_W-1:0] dest_width_r, dest_height_r;
  logic [mnp_pkg::SRC_DIM_W-1:0]  src_width_r, src_height_r;
  logic [mnp_pkg::OFF_W-1:0]      x_offset_r, y_offset_r;

  // Position counters and first pipeline stage
  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic [ROW_W-1:0]  srow_r, srow_nxt;
  logic              s1_valid_r;
  logic [7:0]        s1_mb_r;
  logic [BC_W-1:0]   s1_bc_r;
  logic [ROW_W-1:0]  s1_srow_r;
  logic [7:0]        top_byte;

  logic              accept;
  logic              s2_free;
  logic [CW-1:0]     sw, sh, spitch_raw, spitch, rows, bc_inc, srow_inc;
  logic              wrap_col, wrap_row;

  mnp_pkg::geo_t     geo;
  mnp_pkg::grp_t     grp_data;
  logic              grp_load;
  logic              grp_free;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_width_r  <= mnp_pkg::DEST_WIDTH_RST;
      dest_height_r <= mnp_pkg::DEST_HEIGHT_RST;
      src_width_r   <= mnp_pkg::SRC_WIDTH_RST;
      src_height_r  <= mnp_pkg::SRC_HEIGHT_RST;
      x_offset_r    <= '0;
      y_offset_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mnp_pkg::REG_DEST_WIDTH:  dest_width_r  <= cfg_data[mnp_pkg::DEST_DIM_W-1:0];
        mnp_pkg::REG_DEST_HEIGHT: dest_height_r <= cfg_data[mnp_pkg::DEST_DIM_W-1:0];
        mnp_pkg::REG_SRC_WIDTH:   src_width_r   <= cfg_data;
        mnp_pkg::REG_SRC_HEIGHT:  src_height_r  <= cfg_data;
        mnp_pkg::REG_X_OFFSET:    x_offset_r    <= cfg_data[mnp_pkg::OFF_W-1:0];
        mnp_pkg::REG_Y_OFFSET:    y_offset_r    <= cfg_data[mnp_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !s1_valid_r || s2_free;
  assign accept    = in_tvalid && in_tready;

  // Advance byte column and source row on each request
  always_comb begin
    sw         = mnp_pkg::clamp_u(CW'(src_width_r),  CW'(MAX_SRC_WIDTH));
    sh         = mnp_pkg::clamp_u(CW'(src_height_r), CW'(MAX_SRC_HEIGHT));
    spitch_raw = (sw + CW'(7)) >> 3;
    if (spitch_raw == '0) begin
      spitch = CW'(1);
    end else if (spitch_raw > CW'(STORE_DEPTH)) begin
      spitch = CW'(STORE_DEPTH);
    end else begin
      spitch = spitch_raw;
    end
    rows     = (sh == '0) ? CW'(1) : sh;
    bc_inc   = CW'(bc_r) + CW'(1);
    srow_inc = CW'(srow_r) + CW'(1);
    wrap_col = (bc_inc >= spitch);
    wrap_row = (srow_inc >= rows);

    bc_nxt   = bc_r;
    srow_nxt = srow_r;
    if (accept) begin
      bc_nxt = wrap_col ? '0 : bc_inc[BC_W-1:0];
      if (wrap_col) begin
        srow_nxt = wrap_row ? '0 : srow_inc[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r   <= '0;
      srow_r <= '0;
    end else begin
      bc_r   <= bc_nxt;
      srow_r <= srow_nxt;
    end
  end

  // Stage A: capture the byte while the line store is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mb_r   <= in_tdata;
      s1_bc_r   <= bc_r;
      s1_srow_r <= srow_r;
    end
  end

  mnp_line_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (BC_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (accept && !srow_r[0]),
    .wr_addr (bc_r),
    .wr_data (in_tdata),
    .rd_en   (accept),
    .rd_addr (bc_r),
    .rd_data (top_byte)
  );

  mnp_geometry #(
    .MAX_SRC_WIDTH   (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT  (MAX_SRC_HEIGHT),
    .MAX_DEST_WIDTH  (MAX_DEST_WIDTH),
    .MAX_DEST_HEIGHT (MAX_DEST_HEIGHT)
  ) u_geometry (
    .clk         (clk),
    .dest_width  (dest_width_r),
    .dest_height (dest_height_r),
    .src_width   (src_width_r),
    .src_height  (src_height_r),
    .x_offset    (x_offset_r),
    .y_offset    (y_offset_r),
    .geo         (geo)
  );

  mnp_calc #(
    .BC_W  (BC_W),
    .ROW_W (ROW_W)
  ) u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s2_free  (s2_free),
    .s1_mb    (s1_mb_r),
    .s1_top   (top_byte),
    .s1_bc    (s1_bc_r),
    .s1_srow  (s1_srow_r),
    .geo      (geo),
    .grp_free (grp_free),
    .grp_load (grp_load),
    .grp_data (grp_data)
  );

  mnp_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_load   (grp_load),
    .grp_data   (grp_data),
    .grp_free   (grp_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
